### hdl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants of the stack with search
// Operation and status codes, field widths and the cell shift command.
// ----------------------------------------------------------------------------
package sws_pkg;

	localparam int OP_W     = 3;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_PEEK    = 3'd2,
		OP_SEARCH  = 3'd3,
		OP_DISPLAY = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// shift command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_PUSH  = 2'd1,
		CELL_SHIFT = 2'd2
	} cell_op_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

endpackage

### hdl/sws_req_if.sv
// ----------------------------------------------------------------------------
// sws_req_if: request channel of the stack with search
// Valid/ready channel carrying one operation with its operands.
// ----------------------------------------------------------------------------
interface sws_req_if;
	logic                               valid;
	logic                               ready;
	logic [sws_pkg::OP_W-1:0]           operation;
	logic signed [sws_pkg::DATA_W-1:0]  push_value;
	logic signed [sws_pkg::DATA_W-1:0]  search_key;

	modport source (output valid, operation, push_value, search_key, input ready);
	modport sink   (input valid, operation, push_value, search_key, output ready);
endinterface

### hdl/sws_rsp_if.sv
// ----------------------------------------------------------------------------
// sws_rsp_if: result channel of the stack with search
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sws_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [sws_pkg::STATUS_W-1:0]       status;
	logic signed [sws_pkg::DATA_W-1:0]  value;
	logic [sws_pkg::POS_W-1:0]          position;
	logic                               last;

	modport source (output valid, status, value, position, last, input ready);
	modport sink   (input valid, status, value, position, last, output ready);
endinterface

### hdl/sws_cell.sv
// ----------------------------------------------------------------------------
// sws_cell: one stack entry of the cell chain
// Holds a word, loads from the neighbor above on push, from below on shift.
// ----------------------------------------------------------------------------
module sws_cell (
	input  logic                              clk,
	input  sws_pkg::cell_op_t                 op,
	input  logic signed [sws_pkg::DATA_W-1:0] above,
	input  logic signed [sws_pkg::DATA_W-1:0] below,
	output logic signed [sws_pkg::DATA_W-1:0] data
);

	logic signed [sws_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			sws_pkg::CELL_PUSH:  data_q <= above;
			sws_pkg::CELL_SHIFT: data_q <= below;
			default:             data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

### hdl/stack_with_search_top.sv
// ----------------------------------------------------------------------------
// stack_with_search_top: bounded LIFO stack of signed words with search
// Entries sit in a chain of cells, top entry in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per request (push, pop, peek, search, display);
//   rsp returns the results, one per request except display, which returns
//   every held entry top first with last set on the bottom one, or one empty
//   result when none is held. Push, pop and peek: the result is registered
//   and shows on rsp the cycle after the request, and the next request is
//   taken at once unless rsp stalls. Search and display rotate the whole
//   chain once, DEPTH steps, through the top cell; the next request is taken
//   only after the rotation ends, and the search result is registered at the
//   end of that rotation.
//   Codes 5 to 7 are dropped with no result.
//   rsp holds one result register: while it holds a result that rsp does not
//   take, req.ready stays low and the rotation pauses.
//   Reset clears the entry count, so the stack comes up empty; no result is
//   pending after reset.
// ----------------------------------------------------------------------------
module stack_with_search_top #(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	sws_req_if.sink  req,
	sws_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(DEPTH);

	logic signed [sws_pkg::DATA_W-1:0] cell_data [DEPTH];
	sws_pkg::cell_op_t                 cell_op;

	sws_pkg::state_t                   state_q, state_d;
	logic [CW-1:0]                     count_q, count_d;
	logic [SW-1:0]                     step_q;
	logic                              search_q;
	logic signed [sws_pkg::DATA_W-1:0] key_q;
	logic                              found_q;
	logic [sws_pkg::POS_W-1:0]         pos_q;

	logic                              rsp_valid_q;
	sws_pkg::status_t                  rsp_status_q;
	logic signed [sws_pkg::DATA_W-1:0] rsp_value_q;
	logic [sws_pkg::POS_W-1:0]         rsp_pos_q;
	logic                              rsp_last_q;

	logic                              out_free;
	logic                              req_fire;
	logic                              scan_go;
	logic                              scan_end;
	logic                              in_range;
	logic                              hit;
	logic [CW-1:0]                     step_ext;
	logic [CW-1:0]                     step_p1;
	sws_pkg::op_t                      op;

	logic                              emit;
	sws_pkg::status_t                  e_status;
	logic signed [sws_pkg::DATA_W-1:0] e_value;
	logic [sws_pkg::POS_W-1:0]         e_pos;
	logic                              e_last;

	// cell chain: push enters at cell 0, shift moves toward cell 0 and wraps
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [sws_pkg::DATA_W-1:0] above;
		logic signed [sws_pkg::DATA_W-1:0] below;
		if (k == 0) begin : g_first
			assign above = req.push_value;
		end else begin : g_mid
			assign above = cell_data[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign below = cell_data[0];
		end else begin : g_nlast
			assign below = cell_data[k+1];
		end
		sws_cell u_cell (
			.clk   (clk),
			.op    (cell_op),
			.above (above),
			.below (below),
			.data  (cell_data[k])
		);
	end

	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == sws_pkg::S_IDLE) && out_free;
	assign req_fire = req.valid && req.ready;
	assign op = sws_pkg::op_t'(req.operation);
	assign scan_go = (state_q == sws_pkg::S_SCAN) && out_free;
	assign scan_end = (step_q == SW'(DEPTH - 1));
	assign step_ext = CW'(step_q);
	assign step_p1 = step_ext + CW'(1);
	assign in_range = step_ext < count_q;
	assign hit = in_range && (cell_data[0] == key_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sws_pkg::S_IDLE: begin
				if (req_fire && (op == sws_pkg::OP_SEARCH || op == sws_pkg::OP_DISPLAY)
				    && count_q != '0) begin
					state_d = sws_pkg::S_SCAN;
				end
			end
			sws_pkg::S_SCAN: begin
				if (scan_go && scan_end) begin
					state_d = sws_pkg::S_IDLE;
				end
			end
			default: state_d = sws_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cell_op  = sws_pkg::CELL_HOLD;
		count_d  = count_q;
		emit     = 1'b0;
		e_status = sws_pkg::ST_OK;
		e_value  = '0;
		e_pos    = '0;
		e_last   = 1'b1;
		unique case (state_q)
			sws_pkg::S_IDLE: begin
				if (req_fire) begin
					unique case (op)
						sws_pkg::OP_PUSH: begin
							emit = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								e_status = sws_pkg::ST_FULL;
							end else begin
								cell_op = sws_pkg::CELL_PUSH;
								count_d = count_q + CW'(1);
							end
						end
						sws_pkg::OP_POP: begin
							emit = 1'b1;
							if (count_q == '0) begin
								e_status = sws_pkg::ST_EMPTY;
							end else begin
								e_value = cell_data[0];
								cell_op = sws_pkg::CELL_SHIFT;
								count_d = count_q - CW'(1);
							end
						end
						sws_pkg::OP_PEEK: begin
							emit = 1'b1;
							if (count_q == '0) begin
								e_status = sws_pkg::ST_EMPTY;
							end else begin
								e_value = cell_data[0];
							end
						end
						sws_pkg::OP_SEARCH, sws_pkg::OP_DISPLAY: begin
							if (count_q == '0) begin
								emit     = 1'b1;
								e_status = sws_pkg::ST_EMPTY;
							end
						end
						default: ;
					endcase
				end
			end
			sws_pkg::S_SCAN: begin
				if (scan_go) begin
					// rotate one step; after DEPTH steps the chain is back in place
					cell_op = sws_pkg::CELL_SHIFT;
					if (search_q) begin
						if (scan_end) begin
							emit = 1'b1;
							if (found_q) begin
								e_pos = pos_q;
							end else if (hit) begin
								e_pos = sws_pkg::POS_W'(step_p1);
							end else begin
								e_status = sws_pkg::ST_NOT_FOUND;
							end
						end
					end else if (in_range) begin
						emit    = 1'b1;
						e_value = cell_data[0];
						e_last  = (step_p1 == count_q);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sws_pkg::S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (req_fire) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end else if (scan_go) begin
				step_q <= step_q + SW'(1);
				if (hit && !found_q) begin
					found_q <= 1'b1;
				end
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			search_q <= (op == sws_pkg::OP_SEARCH);
			key_q    <= req.search_key;
		end
		if (scan_go && hit && !found_q) begin
			pos_q <= sws_pkg::POS_W'(step_p1);
		end
		if (emit) begin
			rsp_status_q <= e_status;
			rsp_value_q  <= e_value;
			rsp_pos_q    <= e_pos;
			rsp_last_q   <= e_last;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.value    = rsp_value_q;
	assign rsp.position = rsp_pos_q;
	assign rsp.last     = rsp_last_q;

endmodule

### hdl/sws_checker.sv
// ----------------------------------------------------------------------------
// sws_checker: port-level checks of the stack with search
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module sws_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [sws_pkg::STATUS_W-1:0]      rsp_status,
	input logic signed [sws_pkg::DATA_W-1:0] rsp_value,
	input logic [sws_pkg::POS_W-1:0]         rsp_position,
	input logic                              rsp_last
);

	// no result pending while reset is applied
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	// a stalled result blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while a result is stalled");

	// a search hit is always a single ok result
	a_pos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_position != '0 |->
			rsp_status == sws_pkg::ST_OK && rsp_last && rsp_value == '0)
		else $error("position on a result that is not a search hit");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("stalled result dropped");

endmodule

bind stack_with_search_top sws_checker u_sws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_value    (rsp.value),
	.rsp_position (rsp.position),
	.rsp_last     (rsp.last)
);

### tb/stack_with_search_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_search_top_test: self-checking bench of the stack with search
// Runs a short directed table, then random push/pop/peek/search/display and
// unused-code traffic in fill, drain, overrun and mixed phases, with random
// idling on both channels. Results are checked against the table or a model.
// ----------------------------------------------------------------------------
module stack_with_search_top_test;

	localparam int DEPTH           = 16;
	localparam int RANDOM_REQUESTS = 310;
	localparam int IDLE_LIMIT      = 2000;
	localparam int MAX_SHOWN       = 10;
	localparam int DRAIN_CYCLES    = 2 * DEPTH + 8;
	localparam logic [sws_pkg::OP_W-1:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [sws_pkg::OP_W-1:0] OP_UNUSED_MID = 3'd6;
	localparam logic [sws_pkg::OP_W-1:0] OP_UNUSED_HI  = 3'd7;
	localparam logic signed [sws_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [sws_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		sws_pkg::status_t                  status;
		logic signed [sws_pkg::DATA_W-1:0] value;
		logic [sws_pkg::POS_W-1:0]         position;
		logic                              last;
	} result_t;

	typedef struct {
		logic [sws_pkg::OP_W-1:0]          op;
		logic signed [sws_pkg::DATA_W-1:0] push_value;
		logic signed [sws_pkg::DATA_W-1:0] search_key;
		bit                                typed;
		result_t                           result;
	} request_t;

	typedef enum {PH_OVERRUN, PH_FILL, PH_DRAIN, PH_MIX} phase_t;

	logic clk = 1'b0;
	logic arst_n;

	sws_req_if req_bus ();
	sws_rsp_if rsp_bus ();

	stack_with_search_top #(.DEPTH(DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the stack, entry 0 at the bottom
	logic signed [sws_pkg::DATA_W-1:0] held_words [DEPTH];
	int                                held_count;
	result_t                           step_results [$];
	result_t                           pending_results [$];
	bit                                typed_pending;
	result_t                           typed_result;
	bit                                steady;
	int                                mismatches;
	int                                idle_cycles;

	function automatic result_t make_result(input sws_pkg::status_t status,
			input logic signed [sws_pkg::DATA_W-1:0] value, input int position,
			input bit last);
		result_t r;
		r.status   = status;
		r.value    = value;
		r.position = sws_pkg::POS_W'(position);
		r.last     = last;
		return r;
	endfunction

	// apply one request to the local stack and list the results it causes
	function automatic void predict_stack_results(input logic [sws_pkg::OP_W-1:0] op,
			input logic signed [sws_pkg::DATA_W-1:0] push_value,
			input logic signed [sws_pkg::DATA_W-1:0] search_key);
		bit found;
		step_results.delete();
		found = 1'b0;
		case (op)
			sws_pkg::OP_PUSH: begin
				if (held_count >= DEPTH) begin
					step_results.push_back(make_result(sws_pkg::ST_FULL, '0, 0, 1'b1));
				end else begin
					held_words[held_count] = push_value;
					held_count++;
					step_results.push_back(make_result(sws_pkg::ST_OK, '0, 0, 1'b1));
				end
			end
			sws_pkg::OP_POP: begin
				if (held_count == 0) begin
					step_results.push_back(make_result(sws_pkg::ST_EMPTY, '0, 0, 1'b1));
				end else begin
					held_count--;
					step_results.push_back(make_result(sws_pkg::ST_OK,
							held_words[held_count], 0, 1'b1));
				end
			end
			sws_pkg::OP_PEEK: begin
				if (held_count == 0)
					step_results.push_back(make_result(sws_pkg::ST_EMPTY, '0, 0, 1'b1));
				else
					step_results.push_back(make_result(sws_pkg::ST_OK,
							held_words[held_count-1], 0, 1'b1));
			end
			sws_pkg::OP_SEARCH: begin
				if (held_count == 0) begin
					step_results.push_back(make_result(sws_pkg::ST_EMPTY, '0, 0, 1'b1));
				end else begin
					for (int i = 0; i < held_count && !found; i++) begin
						if (held_words[held_count-1-i] == search_key) begin
							step_results.push_back(make_result(sws_pkg::ST_OK, '0, i + 1,
									1'b1));
							found = 1'b1;
						end
					end
					if (!found)
						step_results.push_back(make_result(sws_pkg::ST_NOT_FOUND, '0, 0,
								1'b1));
				end
			end
			sws_pkg::OP_DISPLAY: begin
				if (held_count == 0) begin
					step_results.push_back(make_result(sws_pkg::ST_EMPTY, '0, 0, 1'b1));
				end else begin
					for (int i = 0; i < held_count; i++)
						step_results.push_back(make_result(sws_pkg::ST_OK,
								held_words[held_count-1-i], 0, i + 1 == held_count));
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic request_t make_request(input logic [sws_pkg::OP_W-1:0] op,
			input logic signed [sws_pkg::DATA_W-1:0] push_value,
			input logic signed [sws_pkg::DATA_W-1:0] search_key,
			input bit typed, input sws_pkg::status_t status,
			input logic signed [sws_pkg::DATA_W-1:0] value, input int position);
		request_t r;
		r.op         = op;
		r.push_value = push_value;
		r.search_key = search_key;
		r.typed      = typed;
		r.result     = make_result(status, value, position, 1'b1);
		return r;
	endfunction

	function automatic logic signed [sws_pkg::DATA_W-1:0] pick_word();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: begin
				case ($urandom_range(0, 3))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return '0;
					default: return -1;
				endcase
			end
			// small pool so that duplicates show up for search
			1, 2, 3: return $signed($urandom_range(0, 7)) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [sws_pkg::OP_W-1:0] OP_OP_UNUSED_PICK();
		return sws_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
	endfunction

	function automatic logic [sws_pkg::OP_W-1:0] pick_op(input phase_t phase);
		int unsigned roll;
		int unsigned push_pct;
		int unsigned pop_pct;
		roll = $urandom_range(0, 99);
		case (phase)
			PH_OVERRUN: return sws_pkg::OP_PUSH;
			PH_FILL:  begin push_pct = 70; pop_pct = 8;  end
			PH_DRAIN: begin push_pct = 10; pop_pct = 60; end
			default:  begin push_pct = 35; pop_pct = 30; end
		endcase
		if (roll < push_pct)
			return sws_pkg::OP_PUSH;
		roll -= push_pct;
		if (roll < pop_pct)
			return sws_pkg::OP_POP;
		case (roll % 7)
			0, 1:    return sws_pkg::OP_PEEK;
			2, 3, 4: return sws_pkg::OP_SEARCH;
			5:       return sws_pkg::OP_DISPLAY;
			default: return OP_OP_UNUSED_PICK();
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input request_t r);
		while (!steady && $urandom_range(0, 99) < 12) begin
			req_bus.valid = 1'b0;
			@(negedge clk);
		end
		req_bus.valid      = 1'b1;
		req_bus.operation  = r.op;
		req_bus.push_value = r.push_value;
		req_bus.search_key = r.search_key;
		typed_pending      = r.typed;
		typed_result       = r.result;
		do
			@(posedge clk);
		while (!req_bus.ready);
		@(negedge clk);
	endtask

	always @(negedge clk)
		rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 12);

	always @(posedge clk) begin : channel_monitor
		result_t got;
		result_t want;
		if (arst_n) begin
			idle_cycles++;
			if (req_bus.valid && req_bus.ready) begin
				idle_cycles = 0;
				predict_stack_results(req_bus.operation, req_bus.push_value,
						req_bus.search_key);
				if (typed_pending)
					pending_results.push_back(typed_result);
				else
					foreach (step_results[i])
						pending_results.push_back(step_results[i]);
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				idle_cycles = 0;
				got.status   = sws_pkg::status_t'(rsp_bus.status);
				got.value    = rsp_bus.value;
				got.position = rsp_bus.position;
				got.last     = rsp_bus.last;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: result with none expected: ", $realtime,
								"status %0d value %0d pos %0d last %0b",
								got.status, got.value, got.position, got.last);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.value !== want.value ||
							got.position !== want.position || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("%0t: mismatch: ", $realtime,
									"exp status %0d value %0d pos %0d last %0b, ",
									want.status, want.value, want.position, want.last,
									"got status %0d value %0d pos %0d last %0b",
									got.status, got.value, got.position, got.last);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		request_t directed [$];
		request_t r;
		phase_t   phase;
		int       phase_left;
		int       issued;
		int       phase_count;

		arst_n             = 1'b0;
		req_bus.valid      = 1'b0;
		req_bus.operation  = sws_pkg::OP_PUSH;
		req_bus.push_value = '0;
		req_bus.search_key = '0;
		rsp_bus.ready      = 1'b0;
		held_count         = 0;
		typed_pending      = 1'b0;
		typed_result       = '0;
		steady             = 1'b0;
		mismatches         = 0;
		idle_cycles        = 0;
		foreach (held_words[i])
			held_words[i] = '0;

		// empty stack, unused codes, extremes, duplicate match from the top
		directed.push_back(make_request(sws_pkg::OP_POP, '0, '0, 1,
				sws_pkg::ST_EMPTY, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_PEEK, '0, '0, 1,
				sws_pkg::ST_EMPTY, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_SEARCH, '0, '0, 1,
				sws_pkg::ST_EMPTY, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_DISPLAY, '0, '0, 1,
				sws_pkg::ST_EMPTY, '0, 0));
		directed.push_back(make_request(OP_UNUSED_LO, '0, '0, 0, sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_PUSH, WORD_MIN, '0, 1,
				sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_PUSH, WORD_MAX, '0, 1,
				sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_PEEK, '0, '0, 1,
				sws_pkg::ST_OK, WORD_MAX, 0));
		directed.push_back(make_request(sws_pkg::OP_SEARCH, '0, WORD_MIN, 1,
				sws_pkg::ST_OK, '0, 2));
		directed.push_back(make_request(sws_pkg::OP_SEARCH, '1, '0, 1,
				sws_pkg::ST_NOT_FOUND, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_DISPLAY, '0, '0, 0,
				sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_PUSH, -1, '0, 1,
				sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_PUSH, WORD_MAX, '0, 1,
				sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_SEARCH, '0, WORD_MAX, 1,
				sws_pkg::ST_OK, '0, 1));
		directed.push_back(make_request(OP_UNUSED_MID, '0, '0, 0, sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(OP_UNUSED_HI, '0, '0, 0, sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_DISPLAY, '0, '0, 0,
				sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_POP, '0, '0, 1,
				sws_pkg::ST_OK, WORD_MAX, 0));
		directed.push_back(make_request(sws_pkg::OP_POP, '0, '0, 1,
				sws_pkg::ST_OK, -1, 0));
		directed.push_back(make_request(sws_pkg::OP_POP, '0, '0, 1,
				sws_pkg::ST_OK, WORD_MAX, 0));
		directed.push_back(make_request(sws_pkg::OP_POP, '0, '0, 1,
				sws_pkg::ST_OK, WORD_MIN, 0));
		directed.push_back(make_request(sws_pkg::OP_POP, '0, '0, 1,
				sws_pkg::ST_EMPTY, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_PUSH, 32'sh5555_5555, '0, 1,
				sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_PUSH, 32'shaaaa_aaaa, '0, 1,
				sws_pkg::ST_OK, '0, 0));
		directed.push_back(make_request(sws_pkg::OP_DISPLAY, '0, '0, 0,
				sws_pkg::ST_OK, '0, 0));

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_request(directed[i]);

		// random phases; the first one overruns the stack to hit full
		issued      = 0;
		phase_count = 0;
		phase       = PH_OVERRUN;
		phase_left  = DEPTH + 3;
		while (issued < RANDOM_REQUESTS) begin
			if (phase_left == 0) begin
				phase_count++;
				phase      = phase_count % 5 == 0 ? PH_OVERRUN : phase_t'($urandom_range(1, 3));
				phase_left = phase == PH_OVERRUN ? DEPTH + 3 : $urandom_range(10, 30);
			end
			phase_left--;
			steady       = issued >= 120 && issued < 200;
			r.op         = pick_op(phase);
			r.push_value = pick_word();
			if (held_count > 0 && $urandom_range(0, 99) < 60)
				r.search_key = held_words[$urandom_range(0, held_count - 1)];
			else
				r.search_key = pick_word();
			r.typed  = 1'b0;
			r.result = '0;
			send_request(r);
			if (r.op < OP_UNUSED_LO)
				issued++;
		end
		req_bus.valid = 1'b0;
		steady        = 1'b0;

		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		mismatches += pending_results.size();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
hdl/sws_pkg.sv
hdl/sws_req_if.sv
hdl/sws_rsp_if.sv
hdl/sws_cell.sv
hdl/stack_with_search_top.sv
hdl/sws_checker.sv
tb/stack_with_search_top_test.sv
